// ===== rtl/pctd_pkg.sv =====
// Shared types, constants and UTF-8 byte helpers for the prefix code trie decoder.
package pctd_pkg;

    localparam int MAX_NODES_DEF    = 1024;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int CP_W             = 21;
    localparam int CODE_W           = 32;
    localparam int LEN_W            = 6;

    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_NOCODE = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_EVAL,
        S_INS_ALLOC,
        S_BIT_EVAL,
        S_BIT_LEAF
    } state_t;

    typedef struct packed {
        logic              start;
        status_t           status;
        logic [CP_W-1:0]   cp;
    } emit_req_t;

    // Index of the final byte of the UTF-8 form of cp (0 to 3).
    function automatic logic [1:0] utf8_last_idx(input logic [CP_W-1:0] cp);
        logic [1:0] r;
        if (cp < CP_W'(21'h80))
            r = 2'd0;
        else if (cp < CP_W'(21'h800))
            r = 2'd1;
        else if (cp < CP_W'(21'h10000))
            r = 2'd2;
        else
            r = 2'd3;
        return r;
    endfunction

    // Byte number idx of the UTF-8 form of cp, whose final byte index is last.
    function automatic logic [7:0] utf8_byte_at(input logic [CP_W-1:0] cp,
                                                 input logic [1:0] last,
                                                 input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (last)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1:
            begin
                if (idx == 2'd0)
                    b = {3'b110, cp[10:6]};
                else
                    b = {2'b10, cp[5:0]};
            end
            2'd2:
            begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                unique case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/pctd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pctd_emit.sv =====
// Result stage: holds one status or codepoint and hands out its result transfers.
module pctd_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  pctd_pkg::emit_req_t req,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          result_status,
    output logic [7:0]          utf8_byte,
    output logic                last_of_run
);

    logic                      valid_reg, valid_next;
    logic [1:0]                idx_reg, idx_next;
    logic [1:0]                last_reg, last_next;
    logic [1:0]                status_reg, status_next;
    logic [pctd_pkg::CP_W-1:0] cp_reg, cp_next;

    always_comb
    begin
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        status_next = status_reg;
        cp_next     = cp_reg;
        if (req.start)
        begin
            valid_next  = 1'b1;
            idx_next    = 2'd0;
            status_next = req.status;
            cp_next     = req.cp;
            last_next   = (req.status == pctd_pkg::ST_BYTE) ?
                          pctd_pkg::utf8_last_idx(req.cp) : 2'd0;
        end
        else if (valid_reg && out_ready)
        begin
            // advance to the next byte, drop valid after the last one
            if (idx_reg == last_reg)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        cp_reg     <= cp_next;
    end

    assign busy          = valid_reg;
    assign out_valid     = valid_reg;
    assign result_status = status_reg;
    assign last_of_run   = (idx_reg == last_reg);
    assign utf8_byte     = (status_reg == pctd_pkg::ST_BYTE) ?
                           pctd_pkg::utf8_byte_at(cp_reg, last_reg, idx_reg) : 8'h00;

endmodule

// ===== rtl/pctd_walk.sv =====
// Trie sequencer: one shared node step unit drives inserts and bit steps.
module pctd_walk #(
    parameter int MAX_NODES    = pctd_pkg::MAX_NODES_DEF,
    parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF,
    localparam int AW = $clog2(MAX_NODES),
    localparam int EW = 2 * AW + 3 + pctd_pkg::CP_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic                          stream_bit,
    input  logic [pctd_pkg::CP_W-1:0]     symbol_value,
    input  logic [pctd_pkg::LEN_W-1:0]    code_length,
    input  logic [pctd_pkg::CODE_W-1:0]   code_bits,
    input  logic                          emit_busy,
    output pctd_pkg::emit_req_t           emit_req,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [EW-1:0]                 mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [EW-1:0]                 mem_rdata
);

    localparam int IW     = $clog2(MAX_CODE_LEN + 1);
    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int C0_LSB = 0;
    localparam int OK0    = AW;
    localparam int C1_LSB = AW + 1;
    localparam int OK1    = 2 * AW + 1;
    localparam int LEAF   = 2 * AW + 2;
    localparam int CP_LSB = 2 * AW + 3;

    pctd_pkg::state_t            state_reg, state_next;
    logic [AW-1:0]               cur_reg, cur_next;
    logic [AW-1:0]               node_reg, node_next;
    logic [NW-1:0]               used_reg, used_next;
    logic                        root_valid_reg, root_valid_next;
    logic                        blank_reg, blank_next;
    logic [IW-1:0]               left_reg, left_next;
    logic [pctd_pkg::CODE_W-1:0] code_reg, code_next;
    logic [pctd_pkg::CP_W-1:0]   cp_reg, cp_next;
    logic                        bit_reg, bit_next;

    logic                        accept;
    logic [IW-1:0]               len_clamped;
    logic [6:0]                  pos;
    logic                        code_bit;
    logic                        step_bit;
    logic [EW-1:0]               entry;
    logic                        sel_ok;
    logic [AW-1:0]               sel_child;
    logic [AW-1:0]               fresh;
    logic                        full;
    logic [EW-1:0]               linked;
    logic [EW-1:0]               leafed;

    assign in_ready = (state_reg == pctd_pkg::S_IDLE) && !emit_busy;
    assign accept   = in_valid && in_ready;

    assign len_clamped = (7'(code_length) > 7'(MAX_CODE_LEN)) ?
                         IW'(MAX_CODE_LEN) : IW'(code_length);

    // Code bits are consumed MSB first; positions above the word read as zero.
    assign pos      = 7'(left_reg) - 7'd1;
    assign code_bit = (pos < 7'd32) ? code_reg[pos[4:0]] : 1'b0;

    // Shared node step unit: pick the child on the branch bit.
    assign step_bit  = (state_reg == pctd_pkg::S_INS_EVAL) ? code_bit : bit_reg;
    assign entry     = blank_reg ? '0 : mem_rdata;
    assign sel_ok    = step_bit ? entry[OK1] : entry[OK0];
    assign sel_child = step_bit ? entry[C1_LSB +: AW] : entry[C0_LSB +: AW];
    assign fresh     = used_reg[AW-1:0];
    assign full      = (used_reg == NW'(MAX_NODES));

    always_comb
    begin
        linked = entry;
        if (step_bit)
        begin
            linked[OK1]           = 1'b1;
            linked[C1_LSB +: AW]  = fresh;
        end
        else
        begin
            linked[OK0]           = 1'b1;
            linked[C0_LSB +: AW]  = fresh;
        end
        leafed                            = entry;
        leafed[LEAF]                      = 1'b1;
        leafed[CP_LSB +: pctd_pkg::CP_W]  = cp_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pctd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (kind)
                        state_next = pctd_pkg::S_BIT_EVAL;
                    else if (len_clamped != '0)
                        state_next = pctd_pkg::S_INS_EVAL;
                end
            end
            pctd_pkg::S_INS_EVAL:
            begin
                if (left_reg == '0)
                    state_next = pctd_pkg::S_IDLE;
                else if (sel_ok)
                    state_next = pctd_pkg::S_INS_EVAL;
                else if (full)
                    state_next = pctd_pkg::S_IDLE;
                else
                    state_next = pctd_pkg::S_INS_ALLOC;
            end
            pctd_pkg::S_INS_ALLOC: state_next = pctd_pkg::S_INS_EVAL;
            pctd_pkg::S_BIT_EVAL:
                state_next = sel_ok ? pctd_pkg::S_BIT_LEAF : pctd_pkg::S_IDLE;
            pctd_pkg::S_BIT_LEAF:  state_next = pctd_pkg::S_IDLE;
            default:               state_next = pctd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        node_next       = node_reg;
        used_next       = used_reg;
        root_valid_next = root_valid_reg;
        blank_next      = blank_reg;
        left_next       = left_reg;
        code_next       = code_reg;
        cp_next         = cp_reg;
        bit_next        = bit_reg;
        mem_we          = 1'b0;
        mem_waddr       = node_reg;
        mem_wdata       = entry;
        mem_re          = 1'b0;
        mem_raddr       = node_reg;
        emit_req        = '0;
        unique case (state_reg)
            pctd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cp_next   = symbol_value;
                    code_next = code_bits;
                    bit_next  = stream_bit;
                    left_next = len_clamped;
                    mem_re    = 1'b1;
                    if (kind)
                    begin
                        mem_raddr  = cur_reg;
                        node_next  = cur_reg;
                        blank_next = (cur_reg == '0) && !root_valid_reg;
                    end
                    else
                    begin
                        mem_raddr  = '0;
                        node_next  = '0;
                        blank_next = !root_valid_reg;
                    end
                end
            end
            pctd_pkg::S_INS_EVAL:
            begin
                if (left_reg == '0)
                begin
                    // end of code: mark the node a leaf with the new codepoint
                    mem_we    = 1'b1;
                    mem_wdata = leafed;
                end
                else if (sel_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sel_child;
                    node_next  = sel_child;
                    left_next  = left_reg - IW'(1);
                    blank_next = 1'b0;
                end
                else if (full)
                begin
                    emit_req.start  = 1'b1;
                    emit_req.status = pctd_pkg::ST_FULL;
                end
                else
                begin
                    // link the next free node under this one
                    mem_we    = 1'b1;
                    mem_wdata = linked;
                    if (node_reg == '0)
                        root_valid_next = 1'b1;
                end
            end
            pctd_pkg::S_INS_ALLOC:
            begin
                // clear the new node; it is known empty, so skip the read
                mem_we     = 1'b1;
                mem_waddr  = fresh;
                mem_wdata  = '0;
                node_next  = fresh;
                used_next  = used_reg + NW'(1);
                left_next  = left_reg - IW'(1);
                blank_next = 1'b1;
            end
            pctd_pkg::S_BIT_EVAL:
            begin
                if (sel_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sel_child;
                    node_next  = sel_child;
                    blank_next = 1'b0;
                end
                else
                begin
                    cur_next        = '0;
                    emit_req.start  = 1'b1;
                    emit_req.status = pctd_pkg::ST_NOCODE;
                end
            end
            pctd_pkg::S_BIT_LEAF:
            begin
                if (entry[LEAF])
                begin
                    cur_next        = '0;
                    emit_req.start  = 1'b1;
                    emit_req.status = pctd_pkg::ST_BYTE;
                    emit_req.cp     = entry[CP_LSB +: pctd_pkg::CP_W];
                end
                else
                begin
                    cur_next = node_reg;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pctd_pkg::S_IDLE;
            cur_reg        <= '0;
            used_reg       <= NW'(1);
            root_valid_reg <= 1'b0;
            blank_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            used_reg       <= used_next;
            root_valid_reg <= root_valid_next;
            blank_reg      <= blank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        left_reg <= left_next;
        code_reg <= code_next;
        cp_reg   <= cp_next;
        bit_reg  <= bit_next;
    end

endmodule

// ===== rtl/prefix_code_trie_decoder.sv =====
// Top level of the binary-trie prefix code decoder with UTF-8 result bytes.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  input   | in_valid / in_ready  | kind, stream_bit, symbol_value, code_length,
//          |                      | code_bits
//  output  | out_valid / out_ready| result_status, utf8_byte, last_of_run
//
//  A bit item reads the current node in its transfer cycle, then picks the child and
//  reads it, then checks it for a leaf; a missing child ends the item at the pick.
//  The node store read port and its registered read data set these steps.
//  An insert reads the root in its transfer cycle, then for each code bit follows an
//  existing child (reading it) or allocates a node (link write, then clear write),
//  and ends with one leaf write, or raises the full report instead.
//  An empty insert ends with its transfer.
//  Reset clears control only; the root has its own valid flop, so no clearing pass.
//  Results leave one per cycle while out_ready is high; in_ready stays low
//  until the last result of an item has been transferred.
module prefix_code_trie_decoder #(
    parameter int MAX_NODES    = pctd_pkg::MAX_NODES_DEF,
    parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic                        stream_bit,
    input  logic [pctd_pkg::CP_W-1:0]   symbol_value,
    input  logic [pctd_pkg::LEN_W-1:0]  code_length,
    input  logic [pctd_pkg::CODE_W-1:0] code_bits,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  result_status,
    output logic [7:0]                  utf8_byte,
    output logic                        last_of_run
);

    // Node entry: codepoint, leaf flag, then child 1 and child 0 each with a valid bit.
    localparam int AW = $clog2(MAX_NODES);
    localparam int EW = 2 * AW + 3 + pctd_pkg::CP_W;

    pctd_pkg::emit_req_t emit_req;
    logic                emit_busy;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       mem_rdata;

    // Sequencer and shared node step unit
    pctd_walk #(
        .MAX_NODES    (MAX_NODES),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .stream_bit   (stream_bit),
        .symbol_value (symbol_value),
        .code_length  (code_length),
        .code_bits    (code_bits),
        .emit_busy    (emit_busy),
        .emit_req     (emit_req),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // Node store; entries other than the root are written before first read
    pctd_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_nodes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result register: hold each byte until its transfer
    pctd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (emit_req),
        .busy          (emit_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_status (result_status),
        .utf8_byte     (utf8_byte),
        .last_of_run   (last_of_run)
    );

    // The block never takes an item while results of the previous one wait.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while results pending");

    // Error results stand alone and close their run.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_status != pctd_pkg::ST_BYTE) |-> last_of_run)
        else $error("error result not marked last");

    // A bit item always needs at least one node read before the next transfer.
    a_bit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind) |=> !in_ready)
        else $error("bit item finished without a node read");

    // Error results carry a zero byte.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_status != pctd_pkg::ST_BYTE) |-> (utf8_byte == 8'h00))
        else $error("error result with nonzero byte");

endmodule

// ===== verif/trie_decode_checker.sv =====
// Checker for the trie decoder: mirrors the trie from accepted inputs and checks every result.
module trie_decode_checker #(
    parameter int MAX_NODES    = pctd_pkg::MAX_NODES_DEF,
    parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        kind,
    input  logic                        stream_bit,
    input  logic [pctd_pkg::CP_W-1:0]   symbol_value,
    input  logic [pctd_pkg::LEN_W-1:0]  code_length,
    input  logic [pctd_pkg::CODE_W-1:0] code_bits,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [1:0]                  result_status,
    input  logic [7:0]                  utf8_byte,
    input  logic                        last_of_run,
    output int                          fail_count,
    output int                          awaited,
    output int                          symbols_seen,
    output int                          nocode_seen,
    output int                          full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_W = $clog2(MAX_NODES);

    typedef struct packed {
        pctd_pkg::status_t status;
        logic [7:0]        octet;
        logic              last;
    } result_t;

    // Trie mirror: per node two links with valid flags, a leaf flag and its codepoint.
    logic [NODE_W-1:0]         child_of  [MAX_NODES][2];
    logic                      child_ok  [MAX_NODES][2];
    logic                      leaf_flag [MAX_NODES];
    logic [pctd_pkg::CP_W-1:0] leaf_cp   [MAX_NODES];
    int unsigned               walk_node;
    int unsigned               nodes_taken;
    result_t                   awaited_results [$];

    function automatic void clear_node(int unsigned n);
        child_ok[n][0] = 1'b0;
        child_ok[n][1] = 1'b0;
        leaf_flag[n]   = 1'b0;
        leaf_cp[n]     = '0;
    endfunction

    function automatic void owe(pctd_pkg::status_t st, logic [7:0] octet, logic last);
        result_t r;
        r.status = st;
        r.octet  = octet;
        r.last   = last;
        awaited_results = {awaited_results, r};
    endfunction

    // Queue the UTF-8 form of a codepoint, chosen by magnitude alone.
    function automatic void owe_utf8(logic [pctd_pkg::CP_W-1:0] cp);
        if (cp < 21'h80)
            owe(pctd_pkg::ST_BYTE, {1'b0, cp[6:0]}, 1'b1);
        else if (cp < 21'h800)
        begin
            owe(pctd_pkg::ST_BYTE, {3'b110, cp[10:6]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[5:0]}, 1'b1);
        end
        else if (cp < 21'h10000)
        begin
            owe(pctd_pkg::ST_BYTE, {4'b1110, cp[15:12]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[11:6]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[5:0]}, 1'b1);
        end
        else
        begin
            owe(pctd_pkg::ST_BYTE, {5'b11110, cp[20:18]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[17:12]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[11:6]}, 1'b0);
            owe(pctd_pkg::ST_BYTE, {2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    // Walk the code MSB first, growing the path; stop with a full report when out of nodes.
    function automatic void insert_code(logic [pctd_pkg::CP_W-1:0]   cp,
                                        logic [pctd_pkg::LEN_W-1:0]  len_field,
                                        logic [pctd_pkg::CODE_W-1:0] code);
        int unsigned depth;
        int unsigned node;
        int unsigned fresh;
        int          b;
        depth = (len_field > MAX_CODE_LEN) ? MAX_CODE_LEN : len_field;
        node  = 0;
        for (int pos = int'(depth) - 1; pos >= 0; pos--)
        begin
            b = (pos < pctd_pkg::CODE_W) ? int'(code[pos]) : 0;
            if (!child_ok[node][b])
            begin
                if (nodes_taken >= MAX_NODES)
                begin
                    owe(pctd_pkg::ST_FULL, 8'h00, 1'b1);
                    return;
                end
                fresh = nodes_taken;
                nodes_taken++;
                clear_node(fresh);
                child_of[node][b] = NODE_W'(fresh);
                child_ok[node][b] = 1'b1;
            end
            node = child_of[node][b];
        end
        if (depth != 0)
        begin
            leaf_flag[node] = 1'b1;
            leaf_cp[node]   = cp;
        end
    endfunction

    // Advance the walk one edge; a leaf or a missing link sends it back to the root.
    function automatic void step_bit(logic bit_in);
        int unsigned node;
        int          b;
        b = int'(bit_in);
        if (!child_ok[walk_node][b])
        begin
            walk_node = 0;
            owe(pctd_pkg::ST_NOCODE, 8'h00, 1'b1);
            return;
        end
        node = child_of[walk_node][b];
        if (leaf_flag[node])
        begin
            walk_node = 0;
            owe_utf8(leaf_cp[node]);
        end
        else
            walk_node = node;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            walk_node    = 0;
            nodes_taken  = 1;
            clear_node(0);
            awaited      = 0;
            fail_count   = 0;
            symbols_seen = 0;
            nocode_seen  = 0;
            full_seen    = 0;
        end
        else
        begin
            // Results first: a result at this edge belongs to an earlier input.
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d byte %02h last %0b",
                           result_status, utf8_byte, last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_status !== want.status)
                    begin
                        $error("result_status: expected %0d, got %0d", want.status, result_status);
                        fail_count++;
                    end
                    if (utf8_byte !== want.octet)
                    begin
                        $error("utf8_byte: expected %02h, got %02h", want.octet, utf8_byte);
                        fail_count++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        fail_count++;
                    end
                    if (want.status == pctd_pkg::ST_FULL)
                        full_seen++;
                    else if (want.status == pctd_pkg::ST_NOCODE)
                        nocode_seen++;
                    else if (want.last)
                        symbols_seen++;
                end
            end
            if (in_valid && in_ready)
            begin
                if (kind)
                    step_bit(stream_bit);
                else
                    insert_code(symbol_value, code_length, code_bits);
            end
            awaited = awaited_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the prefix code trie decoder: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Item counts steer the run: directed part, then mixed traffic, a stretch of long
    // inserts that exhausts the node store, and mixed traffic again on the full store.
    localparam int FILL_FROM    = 200;
    localparam int FILL_TO      = 270;
    localparam int ITEM_GOAL    = 330;
    localparam int PHASE_ITEMS  = 40;
    localparam int SHORT_MAX    = 12;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        int          len;
        logic [31:0] bits;
    } code_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        kind;
    logic                        stream_bit;
    logic [pctd_pkg::CP_W-1:0]   symbol_value;
    logic [pctd_pkg::LEN_W-1:0]  code_length;
    logic [pctd_pkg::CODE_W-1:0] code_bits;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [1:0]                  result_status;
    logic [7:0]                  utf8_byte;
    logic                        last_of_run;

    int fail_count;
    int awaited;
    int symbols_seen;
    int nocode_seen;
    int full_seen;

    int    send_idle_pct;
    int    stall_pct;
    int    items_sent;
    int    inserts_sent;
    int    bits_sent;
    int    cycles = 0;
    code_t short_codes [$];
    code_t long_codes  [$];

    prefix_code_trie_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .stream_bit    (stream_bit),
        .symbol_value  (symbol_value),
        .code_length   (code_length),
        .code_bits     (code_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_status (result_status),
        .utf8_byte     (utf8_byte),
        .last_of_run   (last_of_run)
    );

    trie_decode_checker watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .stream_bit    (stream_bit),
        .symbol_value  (symbol_value),
        .code_length   (code_length),
        .code_bits     (code_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_status (result_status),
        .utf8_byte     (utf8_byte),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .awaited       (awaited),
        .symbols_seen  (symbols_seen),
        .nocode_seen   (nocode_seen),
        .full_seen     (full_seen)
    );

    always #5ns clk = ~clk;

    // Receiver side: drop out_ready at random with the current phase's stall rate.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if the traffic never drains.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results still awaited", cycles, awaited);
            $display("status: fail");
            $finish;
        end
    end

    // Present one item at the falling edge and hold it until the transfer happens.
    // Idle cycles drop in_valid first; a back-to-back item keeps valid high.
    task automatic send(input logic                        k,
                        input logic                        sb,
                        input logic [pctd_pkg::CP_W-1:0]   cp,
                        input logic [pctd_pkg::LEN_W-1:0]  len,
                        input logic [pctd_pkg::CODE_W-1:0] code);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        stream_bit   <= sb;
        symbol_value <= cp;
        code_length  <= len;
        code_bits    <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k)
            bits_sent++;
        else
            inserts_sent++;
        // Empty inserts are skipped by the block; leave them out of the item count.
        if (k || len != 0)
            items_sent++;
        // Rotate the idling phase: none, sender idle, receiver stall, both.
        case ((items_sent / PHASE_ITEMS) % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 77;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 77;
            end
            default:
            begin
                send_idle_pct = 23;
                stall_pct     = 23;
            end
        endcase
    endtask

    // Decode one stream bit; the insert fields carry random junk to toggle them.
    task automatic send_bit(input logic b);
        send(1'b1, b, 21'($urandom_range(21'h1FFFFF)), 6'($urandom_range(63)), $urandom);
    endtask

    // Insert a code and keep it for later replay as a decode sequence.
    task automatic send_insert(input logic [pctd_pkg::CP_W-1:0]   cp,
                               input logic [pctd_pkg::LEN_W-1:0]  len,
                               input logic [pctd_pkg::CODE_W-1:0] code);
        code_t c;
        send(1'b0, 1'($urandom_range(1)), cp, len, code);
        c.len  = (len > pctd_pkg::MAX_CODE_LEN_DEF) ? pctd_pkg::MAX_CODE_LEN_DEF : len;
        c.bits = code;
        if (c.len != 0 && c.len <= SHORT_MAX)
            short_codes = {short_codes, c};
        else if (c.len > SHORT_MAX)
            long_codes = {long_codes, c};
    endtask

    // Insert random content at a given length, spreading codepoints over all UTF-8 sizes.
    task automatic insert_random(input int len);
        logic [pctd_pkg::CP_W-1:0] cp;
        case ($urandom_range(3))
            0:       cp = 21'($urandom_range(21'h7F));
            1:       cp = 21'($urandom_range(21'h7FF, 21'h80));
            2:       cp = 21'($urandom_range(21'hFFFF, 21'h800));
            default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        send_insert(cp, 6'(len), $urandom);
    endtask

    // Feed a known code MSB first so the walk reaches a leaf; short codes most of the time.
    task automatic replay_code();
        code_t c;
        if (short_codes.size() != 0 && ($urandom_range(5) != 0 || long_codes.size() == 0))
            c = short_codes[$urandom_range(short_codes.size() - 1)];
        else if (long_codes.size() != 0)
            c = long_codes[$urandom_range(long_codes.size() - 1)];
        else
        begin
            send_bit(1'($urandom_range(1)));
            return;
        end
        for (int i = c.len - 1; i >= 0; i--)
            send_bit(c.bits[i]);
    endtask

    // One random step: an insert, a well-formed code replay, or a few noise bits.
    // While filling, nearly every step is a full-length insert with random bits.
    task automatic mixed_step(input bit filling);
        int pick;
        int n;
        pick = $urandom_range(99);
        if (filling)
        begin
            if (pick < 90)
                insert_random(pctd_pkg::MAX_CODE_LEN_DEF);
            else
                replay_code();
        end
        else if (pick < 35)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                insert_random($urandom_range(32, 24));
            else if (pick < 90)
                insert_random($urandom_range(10, 1));
            else
                insert_random(0);
        end
        else if (pick < 85)
            replay_code();
        else
        begin
            n = $urandom_range(4, 1);
            repeat (n)
                send_bit(1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = 1'b0;
        stream_bit    = 1'b0;
        symbol_value  = '0;
        code_length   = '0;
        code_bits     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        items_sent    = 0;
        inserts_sent  = 0;
        bits_sent     = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a step on the empty trie finds no code; an empty insert is skipped.
        send_bit(1'b1);
        send_insert(21'h00ABC, 6'd0, 32'hFFFF_FFFF);
        // Build a small trie: one-, two- and three-byte symbols, a surrogate, and an
        // overlong all-ones code that clamps to the maximum length.
        send_insert(21'h00041, 6'd1, 32'h0000_0000);
        send_insert(21'h007FF, 6'd2, 32'h0000_0002);
        send_insert(21'h0D800, 6'd3, 32'h0000_0006);
        send_insert(21'h10FFFF, 6'd63, 32'hFFFF_FFFF);
        // Repeat a code to overwrite its symbol with the top of the 21-bit space.
        send_insert(21'h1FFFFF, 6'd2, 32'h0000_0002);
        // End a code on an inner node of the all-ones path.
        send_insert(21'h00080, 6'd4, 32'h0000_000F);
        // Extend below an existing leaf; decoding must still stop at that leaf.
        send_insert(21'h00800, 6'd3, 32'h0000_0003);
        // Decode: leaf under the path extension, inner step then overwritten symbol,
        // surrogate, leaf on an inner node, and a missing child deep in the trie.
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        repeat (4)
            send_bit(1'b1);
        repeat (3)
            send_bit(1'b1);
        send_bit(1'b0);

        // Random traffic, then exhaust the node store, then keep going on the full store.
        while (items_sent < FILL_FROM)
            mixed_step(1'b0);
        while (items_sent < FILL_TO)
            mixed_step(1'b1);
        while (items_sent < ITEM_GOAL)
            mixed_step(1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        // Hold a while longer so a late or extra result still gets caught.
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d inserts and %0d stream bits under four idling phases",
                 inserts_sent, bits_sent);
        $display("decoded %0d symbols, saw %0d no-code errors and %0d store-full reports",
                 symbols_seen, nocode_seen, full_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
